>>> hdl/lateral_friction_force_sim_macros.svh
// Assertion helpers, used by the top-level file to check its own logic.
`ifndef LATERAL_FRICTION_FORCE_SIM_MACROS_SVH
`define LATERAL_FRICTION_FORCE_SIM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lffs_pkg.sv
package lffs_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_SLOPE_GAIN     = 2'd0;
    localparam logic [1:0] REG_FRICTION_COEF  = 2'd1;
    localparam logic [1:0] REG_NORMAL_LOAD    = 2'd2;
    localparam logic [1:0] REG_ADHESION_FORCE = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_SLOPE_GAIN     = 32'd65536;
    localparam logic [22:0] RST_FRICTION_COEF  = 23'd65536;
    localparam logic [15:0] RST_NORMAL_LOAD    = 16'd64;
    localparam logic [15:0] RST_ADHESION_FORCE = 16'd64;

    // Fixed-point constants.
    localparam logic [53:0] SLOPE_MAX = 54'd16777216;
    localparam logic [48:0] ONE_Q32   = 49'h1_0000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX   = 32'h8000_0000;

    typedef struct packed {
        logic signed [19:0] height;
        logic               row_end;
    } t_in;

    typedef struct packed {
        logic signed [31:0] forward_force;
        logic signed [31:0] reverse_force;
        logic               saturated;
        logic               last_of_row;
    } t_out;

    typedef struct packed {
        logic [31:0] slope_gain;
        logic [22:0] friction_coef;
        logic [15:0] normal_load;
        logic [15:0] adhesion_force;
    } t_cfg;

    // One force computation handed to the engine.
    typedef struct packed {
        logic signed [20:0] diff;
        logic               doubled;
        logic               last;
    } t_eng_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage

>>> hdl/lffs_engine.sv
module lffs_engine import lffs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_eng_req  i_req,
    input  t_cfg      i_cfg,
    input  logic      i_ack,
    output t_eng_stat o_stat,
    output t_out      o_res
);

    localparam logic [4:0] E_IDLE = 5'd0;
    localparam logic [4:0] E_S0   = 5'd1;
    localparam logic [4:0] E_S1   = 5'd2;
    localparam logic [4:0] E_SS0  = 5'd3;
    localparam logic [4:0] E_SS1  = 5'd4;
    localparam logic [4:0] E_SQ   = 5'd5;
    localparam logic [4:0] E_ML   = 5'd6;
    localparam logic [4:0] E_MA   = 5'd7;
    localparam logic [4:0] E_MR0  = 5'd8;
    localparam logic [4:0] E_MR1  = 5'd9;
    localparam logic [4:0] E_LS   = 5'd10;
    localparam logic [4:0] E_MS0  = 5'd11;
    localparam logic [4:0] E_MS1  = 5'd12;
    localparam logic [4:0] E_FD   = 5'd13;
    localparam logic [4:0] E_DIV  = 5'd14;
    localparam logic [4:0] E_FW   = 5'd15;
    localparam logic [4:0] E_RD   = 5'd16;
    localparam logic [4:0] E_RW   = 5'd17;
    localparam logic [4:0] E_DONE = 5'd18;

    logic [4:0]  r_state;
    logic        r_neg;
    logic        r_last;
    logic        r_dbl;
    logic        r_sat;
    logic        r_rneg;
    logic        r_divrev;
    logic [20:0] r_mag;
    logic [24:0] r_s;
    logic [53:0] r_acc;
    logic [48:0] r_rem;
    logic [49:0] r_root;
    logic [49:0] r_bit;
    logic [5:0]  r_cnt;
    logic [63:0] r_p;
    logic [56:0] r_q;
    logic [38:0] r_ma;
    logic [47:0] r_ms;
    logic [63:0] r_num;
    logic [48:0] r_den;
    logic [31:0] r_fwd;
    logic [31:0] r_rev;

    logic [39:0] mul_a;
    logic [15:0] mul_b;
    logic [55:0] prod;
    logic [52:0] s_sum;
    logic [53:0] s_full;
    logic [49:0] sq_try;
    logic [49:0] rem_sh;
    logic        div_ge;
    logic [32:0] fwd_den;
    logic        p_ge_q;

    // Shared multiplier: operands picked by the sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            E_S0: begin
                mul_a = {19'b0, r_mag};
                mul_b = i_cfg.slope_gain[15:0];
            end
            E_S1: begin
                mul_a = {19'b0, r_mag};
                mul_b = i_cfg.slope_gain[31:16];
            end
            E_SS0: begin
                mul_a = {15'b0, r_s};
                mul_b = r_s[15:0];
            end
            E_SS1: begin
                mul_a = {15'b0, r_s};
                mul_b = {7'b0, r_s[24:16]};
            end
            E_ML: begin
                mul_a = {17'b0, i_cfg.friction_coef};
                mul_b = i_cfg.normal_load;
            end
            E_MA: begin
                mul_a = {17'b0, i_cfg.friction_coef};
                mul_b = i_cfg.adhesion_force;
            end
            E_MR0: begin
                mul_a = {1'b0, r_ma};
                mul_b = r_root[15:0];
            end
            E_MR1: begin
                mul_a = {1'b0, r_ma};
                mul_b = {7'b0, r_root[24:16]};
            end
            E_LS: begin
                mul_a = {15'b0, r_s};
                mul_b = i_cfg.normal_load;
            end
            E_MS0: begin
                mul_a = {15'b0, r_s};
                mul_b = i_cfg.friction_coef[15:0];
            end
            E_MS1: begin
                mul_a = {15'b0, r_s};
                mul_b = {9'b0, i_cfg.friction_coef[22:16]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Slope assembly, doubling at the row ends.
    assign s_sum  = r_acc[52:0] + {prod[36:0], 16'b0};
    assign s_full = r_dbl ? {s_sum, 1'b0} : {1'b0, s_sum};

    // Square root and divider steps.
    assign sq_try  = r_root + r_bit;
    assign rem_sh  = {r_rem, r_num[63]};
    assign div_ge  = rem_sh >= {1'b0, r_den};
    assign fwd_den = ONE_Q32[32:0] - {1'b0, r_ms[31:0]};
    assign p_ge_q  = r_p >= {7'b0, r_q};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_req.diff[20];
                        r_mag   <= i_req.diff[20] ? 21'(-i_req.diff) : i_req.diff;
                        r_dbl   <= i_req.doubled;
                        r_last  <= i_req.last;
                        r_sat   <= 1'b0;
                        r_state <= E_S0;
                    end
                end
                E_S0: begin
                    r_acc   <= prod[53:0];
                    r_state <= E_S1;
                end
                E_S1: begin
                    if (s_full > SLOPE_MAX) begin
                        r_s   <= SLOPE_MAX[24:0];
                        r_sat <= 1'b1;
                    end else begin
                        r_s <= s_full[24:0];
                    end
                    r_state <= E_SS0;
                end
                E_SS0: begin
                    r_acc   <= prod[53:0];
                    r_state <= E_SS1;
                end
                E_SS1: begin
                    r_rem   <= ONE_Q32 + r_acc[48:0] + {prod[32:0], 16'b0};
                    r_root  <= '0;
                    r_bit   <= 50'h1 << 48;
                    r_cnt   <= 6'd24;
                    r_state <= E_SQ;
                end
                E_SQ: begin
                    if ({1'b0, r_rem} >= sq_try) begin
                        r_rem  <= r_rem - sq_try[48:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) begin
                        r_state <= E_ML;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                E_ML: begin
                    r_p     <= {9'b0, prod[38:0], 16'b0};
                    r_state <= E_MA;
                end
                E_MA: begin
                    r_ma    <= prod[38:0];
                    r_state <= E_MR0;
                end
                E_MR0: begin
                    r_p     <= r_p + {8'b0, prod};
                    r_state <= E_MR1;
                end
                E_MR1: begin
                    r_p     <= r_p + {prod[47:0], 16'b0};
                    r_state <= E_LS;
                end
                E_LS: begin
                    r_q     <= {prod[40:0], 16'b0};
                    r_state <= E_MS0;
                end
                E_MS0: begin
                    r_ms    <= prod[47:0];
                    r_state <= E_MS1;
                end
                E_MS1: begin
                    r_ms    <= r_ms + {prod[31:0], 16'b0};
                    r_state <= E_FD;
                end
                // Forward force: a non-positive denominator saturates.
                E_FD: begin
                    if (r_ms[47:32] != '0) begin
                        r_sat   <= 1'b1;
                        r_fwd   <= POS_MAX;
                        r_state <= E_RD;
                    end else begin
                        r_num    <= r_p + {7'b0, r_q};
                        r_den    <= {16'b0, fwd_den};
                        r_rem    <= '0;
                        r_cnt    <= 6'd63;
                        r_divrev <= 1'b0;
                        r_state  <= E_DIV;
                    end
                end
                // Restoring division, one quotient bit per cycle.
                E_DIV: begin
                    r_rem <= div_ge ? 49'(rem_sh - {1'b0, r_den}) : rem_sh[48:0];
                    r_num <= {r_num[62:0], div_ge};
                    if (r_cnt == '0) begin
                        r_state <= r_divrev ? E_RW : E_FW;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                E_FW: begin
                    if (r_num[63:31] != '0) begin
                        r_sat <= 1'b1;
                        r_fwd <= POS_MAX;
                    end else begin
                        r_fwd <= r_num[31:0];
                    end
                    r_state <= E_RD;
                end
                E_RD: begin
                    r_num    <= p_ge_q ? (r_p - {7'b0, r_q}) : ({7'b0, r_q} - r_p);
                    r_rneg   <= !p_ge_q;
                    r_den    <= ONE_Q32 + {1'b0, r_ms};
                    r_rem    <= '0;
                    r_cnt    <= 6'd63;
                    r_divrev <= 1'b1;
                    r_state  <= E_DIV;
                end
                E_RW: begin
                    if (!r_rneg) begin
                        if (r_num[63:31] != '0) begin
                            r_sat <= 1'b1;
                            r_rev <= POS_MAX;
                        end else begin
                            r_rev <= r_num[31:0];
                        end
                    end else if (r_num[63:32] != '0 || (r_num[31] && r_num[30:0] != '0)) begin
                        r_sat <= 1'b1;
                        r_rev <= NEG_MAX;
                    end else begin
                        r_rev <= 32'(-r_num[31:0]);
                    end
                    r_state <= E_DONE;
                end
                E_DONE: begin
                    if (i_ack) begin
                        r_state <= E_IDLE;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    // Result, with the two forces swapped for a falling slope.
    assign o_res.forward_force = r_neg ? r_rev : r_fwd;
    assign o_res.reverse_force = r_neg ? r_fwd : r_rev;
    assign o_res.saturated     = r_sat;
    assign o_res.last_of_row   = r_last;

    assign o_stat.busy = (r_state != E_IDLE);
    assign o_stat.done = (r_state == E_DONE);

endmodule

>>> hdl/lateral_friction_force_sim.sv
// Lateral friction force simulator. Height samples enter row by row; each result
// (forward force, reverse force, saturation flag, end-of-row mark) belongs to the
// sample before the one just taken, and the sample marking a row end yields two
// results, or one for a single-sample row. A sample that only starts a row does
// not stall the input. Each result is computed by one iterative engine, which
// skips the forward division when the forward denominator is not positive; the
// 25-step square root and the two 64-step restoring divisions dominate its work.
// A row-end sample with two results holds the input until both are done. The
// input stays stalled until the last result of the current sample has moved into
// the output register, so a stalled output channel holds the input longer. The
// user must write configuration through the plain write port only while the
// block is idle; the block itself does not enforce this.
`include "lateral_friction_force_sim_macros.svh"

module lateral_friction_force_sim import lffs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_WAIT    = 2'd1;
    localparam logic [1:0] S_WAIT2   = 2'd2;
    localparam logic [1:0] S_LAUNCH2 = 2'd3;

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         r_fill;
    logic signed [19:0] r_older;
    logic signed [19:0] r_newer;
    t_eng_req           r_req2;
    t_cfg               r_cfg;
    logic               r_out_valid;
    t_out               r_out;

    logic               accept;
    logic               load;
    logic               eng_start;
    t_eng_req           eng_req;
    t_eng_stat          eng_stat;
    t_out               eng_res;
    logic signed [20:0] d_new;
    logic signed [20:0] d_old;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign load       = eng_stat.done && (!r_out_valid || !i_out_stall);

    assign d_new = {i_in_data.height[19], i_in_data.height} - {r_newer[19], r_newer};
    assign d_old = {i_in_data.height[19], i_in_data.height} - {r_older[19], r_older};

    // Engine launch: the held row-end result, or the first result of a new sample.
    always_comb begin
        eng_start = 1'b0;
        eng_req   = '0;
        priority if (r_state == S_LAUNCH2) begin
            eng_start = 1'b1;
            eng_req   = r_req2;
        end else if (accept && r_fill == FILL_EMPTY) begin
            eng_start       = i_in_data.row_end;
            eng_req.diff    = '0;
            eng_req.doubled = 1'b0;
            eng_req.last    = 1'b1;
        end else if (accept) begin
            eng_start       = 1'b1;
            eng_req.diff    = (r_fill == FILL_ONE) ? d_new : d_old;
            eng_req.doubled = (r_fill == FILL_ONE);
            eng_req.last    = 1'b0;
        end else begin
            eng_start = 1'b0;
        end
    end

    // Row tracking and sequencing of the results of one sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= FILL_EMPTY;
            r_older <= '0;
            r_newer <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_fill == FILL_EMPTY) begin
                            if (i_in_data.row_end) begin
                                r_state <= S_WAIT;
                            end else begin
                                r_newer <= i_in_data.height;
                                r_fill  <= FILL_ONE;
                            end
                        end else begin
                            r_older <= r_newer;
                            r_newer <= i_in_data.height;
                            if (i_in_data.row_end) begin
                                r_req2.diff    <= d_new;
                                r_req2.doubled <= 1'b1;
                                r_req2.last    <= 1'b1;
                                r_fill         <= FILL_EMPTY;
                                r_state        <= S_WAIT2;
                            end else begin
                                r_fill  <= FILL_TWO;
                                r_state <= S_WAIT;
                            end
                        end
                    end
                end
                S_WAIT: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_WAIT2: begin
                    if (load) begin
                        r_state <= S_LAUNCH2;
                    end
                end
                S_LAUNCH2: begin
                    r_state <= S_WAIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slope_gain     <= RST_SLOPE_GAIN;
            r_cfg.friction_coef  <= RST_FRICTION_COEF;
            r_cfg.normal_load    <= RST_NORMAL_LOAD;
            r_cfg.adhesion_force <= RST_ADHESION_FORCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SLOPE_GAIN:     r_cfg.slope_gain     <= i_cfg_data;
                REG_FRICTION_COEF:  r_cfg.friction_coef  <= i_cfg_data[22:0];
                REG_NORMAL_LOAD:    r_cfg.normal_load    <= i_cfg_data[15:0];
                REG_ADHESION_FORCE: r_cfg.adhesion_force <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Output register: takes a finished result whenever the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    lffs_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eng_start),
        .i_req   (eng_req),
        .i_cfg   (r_cfg),
        .i_ack   (load),
        .o_stat  (eng_stat),
        .o_res   (eng_res)
    );

    // A new computation never starts over one still in flight.
    `LFFS_ASSERT_NOW(a_start_idle, eng_start, !eng_stat.busy, "engine started while busy")
    // A finished result always has a sample waiting for it.
    `LFFS_ASSERT_NOW(a_done_owned, eng_stat.done, r_state != S_IDLE, "result with no owner")
    // A result moved out of the engine shows up on the output next cycle.
    `LFFS_ASSERT_NEXT(a_load_shown, load, o_out_valid, "loaded result not presented")

endmodule
